/* sv/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked check that is switched off while reset is held.
`define TRIC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define TRIC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TRIC_ASSERT(label, clk, rst_n, prop, msg)

`define TRIC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* sv/tric_pkg.sv */
`default_nettype none

package tric_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS    = 2'd0,
        CFG_NUM_COLS    = 2'd1,
        CFG_DIAG_OFFSET = 2'd2,
        CFG_UPPER_MODE  = 2'd3
    } t_cfg_idx;

    // Width of the linear index.
    localparam int IDX_W = 32;

    // Per-item control that rides with the data through the pipeline.
    typedef struct packed {
        logic div;  // item is in the rectangle part (divide by the column count)
        logic ok;   // index lies inside the triangle
    } t_flags;

endpackage

`default_nettype wire

/* sv/triangle_index_to_coordinate.sv */
`default_nettype none

// Channel   | Dir | Signals                     | Contents
// ----------+-----+-----------------------------+-------------------------------------
// s_axis    | in  | tvalid tready tdata[31:0]   | linear_index
// m_axis    | out | tvalid tready tdata tuser   | tdata: out_row, out_col; tuser: in_range
// cfg       | in  | we idx data[DIM_WIDTH:0]    | num_rows, num_cols, diag_offset, upper_mode
//
// One transaction per cycle in and out while m_axis is ready; the pipeline has
// one stage per bit of the row number.
// Geometry follows a register write through three register stages.
// Reset clears the configuration and every stage valid bit.
// A stall holds the unbroken run of full stages at the output; stages above an empty one keep moving.

`include "assert_macros.svh"

module triangle_index_to_coordinate #(
    parameter int  DIM_WIDTH = 16,
    localparam int ODW       = ((2 * DIM_WIDTH + 7) / 8) * 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [tric_pkg::IDX_W-1:0]    i_s_axis_tdata,   // [31:0] linear_index
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [ODW-1:0]                     o_m_axis_tdata,   // out_row, out_col, zero pad
    output logic [0:0]                         o_m_axis_tuser,   // [0] in_range
    input  wire logic                          i_cfg_we,
    input  wire logic [tric_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DIM_WIDTH:0]            i_cfg_data
);
    import tric_pkg::*;

    localparam int DW = DIM_WIDTH;
    localparam int FW = DIM_WIDTH + 2;
    localparam int PW = 2 * DIM_WIDTH + 2;
    localparam int WW = (PW > IDX_W + 1) ? PW : IDX_W + 1;
    localparam int NS = DIM_WIDTH + 5;
    localparam int P4 = 3;

    // Configuration registers.
    logic [DW-1:0]        r_num_rows;
    logic [DW-1:0]        r_num_cols;
    logic signed [DW:0]   r_diag_offset;
    logic                 r_upper_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows    <= '0;
            r_num_cols    <= '0;
            r_diag_offset <= '0;
            r_upper_mode  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NUM_ROWS:    r_num_rows    <= i_cfg_data[DW-1:0];
                CFG_NUM_COLS:    r_num_cols    <= i_cfg_data[DW-1:0];
                CFG_DIAG_OFFSET: r_diag_offset <= i_cfg_data;
                CFG_UPPER_MODE:  r_upper_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Geometry, first stage: split sizes and row bases.
    logic            w_k_neg;
    logic [DW:0]     w_k_neg_val;
    logic [DW:0]     w_k_mag;
    logic            w_k_pos;
    logic [DW:0]     w_rows_x;
    logic [DW-1:0]   w_rr;
    logic [DW-1:0]   w_mu;
    logic [DW-1:0]   w_left;
    logic [DW-1:0]   w_hu;
    logic            w_live;
    logic [DW-1:0]   w_r0;
    logic [DW+1:0]   w_k_inc;
    logic [DW-1:0]   w_ml;
    logic [DW-1:0]   w_span;
    logic [DW-1:0]   w_avail;
    logic [DW-1:0]   w_hl;

    always_comb begin
        w_k_neg     = r_diag_offset[DW];
        w_k_neg_val = -r_diag_offset;
        w_k_mag     = w_k_neg ? w_k_neg_val : r_diag_offset;
        w_k_pos     = !w_k_neg && (w_k_mag != '0);
        w_rows_x    = {1'b0, r_num_rows};
        // Upper: full rows first, then rows shrinking by one.
        if (w_k_neg) begin
            w_rr = (w_k_mag < w_rows_x) ? w_k_mag[DW-1:0] : r_num_rows;
        end else begin
            w_rr = '0;
        end
        if (w_k_pos) begin
            w_mu = ({1'b0, r_num_cols} > w_k_mag) ? (r_num_cols - w_k_mag[DW-1:0]) : '0;
        end else begin
            w_mu = r_num_cols;
        end
        w_left = r_num_rows - w_rr;
        w_hu   = (w_mu < w_left) ? w_mu : w_left;
        // Lower: empty rows skipped, rows growing by one, then full rows.
        w_live  = !w_k_neg || (w_k_mag < w_rows_x);
        w_r0    = w_k_neg ? w_k_mag[DW-1:0] : '0;
        w_k_inc = {1'b0, w_k_mag} + (DW+2)'(1);
        if (w_k_pos) begin
            w_ml = (w_k_inc < (DW+2)'(r_num_cols)) ? w_k_inc[DW-1:0] : r_num_cols;
        end else begin
            w_ml = DW'(1);
        end
        w_span  = r_num_cols - w_ml + DW'(1);
        w_avail = r_num_rows - w_r0;
        w_hl    = (w_span < w_avail) ? w_span : w_avail;
    end

    logic            r_d1_ne;
    logic            r_d1_up;
    logic [DW-1:0]   r_d1_m;
    logic [DW-1:0]   r_d1_h;
    logic [DW-1:0]   r_d1_rows;
    logic [DW-1:0]   r_d1_tbase;
    logic [DW-1:0]   r_d1_rbase;
    logic [DW-1:0]   r_d1_cbase;

    always_ff @(posedge i_clk) begin
        r_d1_ne    <= (r_num_rows != '0) && (r_num_cols != '0) && (r_upper_mode || w_live);
        r_d1_up    <= r_upper_mode;
        r_d1_m     <= r_upper_mode ? w_mu : w_ml;
        r_d1_h     <= r_upper_mode ? w_hu : w_hl;
        r_d1_rows  <= r_upper_mode ? w_rr : (w_avail - w_hl);
        r_d1_tbase <= r_upper_mode ? w_rr : w_r0;
        r_d1_rbase <= r_upper_mode ? '0 : (w_r0 + w_hl);
        r_d1_cbase <= (r_upper_mode && w_k_pos) ? w_k_mag[DW-1:0] : '0;
    end

    // Geometry, second stage: rectangle and trapezoid element counts.
    logic [FW-1:0]   w_d2_fac;
    logic [PW-1:0]   w_d2_prod;
    logic [2*DW-1:0] r_d2_rect;
    logic [PW-1:0]   r_d2_trap;

    always_comb begin
        if (r_d1_up) begin
            w_d2_fac = (FW'(r_d1_m) << 1) + FW'(1) - FW'(r_d1_h);
        end else begin
            w_d2_fac = (FW'(r_d1_m) << 1) - FW'(1) + FW'(r_d1_h);
        end
        w_d2_prod = PW'(r_d1_h) * PW'(w_d2_fac);
    end

    always_ff @(posedge i_clk) begin
        r_d2_rect <= (2*DW)'(r_d1_rows) * (2*DW)'(r_num_cols);
        r_d2_trap <= w_d2_prod >> 1;
    end

    // Geometry, third stage: total size and the split point of the index.
    logic [WW-1:0]   r_d3_size;
    logic [WW-1:0]   r_d3_split;

    always_ff @(posedge i_clk) begin
        r_d3_size  <= r_d1_ne ? (WW'(r_d2_rect) + WW'(r_d2_trap)) : '0;
        r_d3_split <= r_d1_up ? WW'(r_d2_rect) : WW'(r_d2_trap);
    end

    // Stage enables: a stage loads when it or any stage below it is empty, or the output is ready.
    logic [NS-1:0]   r_v;
    logic [NS-1:0]   n_v;
    logic [NS-1:0]   w_en;

    for (genvar s = 0; s < NS; s++) begin : g_en
        assign w_en[s] = i_m_axis_tready || !(&r_v[NS-1:s]);
    end

    // Each enabled stage takes the valid bit of the stage above it.
    assign n_v = (w_en & {r_v[NS-2:0], i_s_axis_tvalid}) | (~w_en & r_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_s_axis_tready = w_en[0];

    // The index waits while the geometry of a fresh write settles.
    logic [IDX_W-1:0] r_x1;
    logic [IDX_W-1:0] r_x2;
    logic [IDX_W-1:0] r_x3;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_x1 <= i_s_axis_tdata;
        end
        if (w_en[1]) begin
            r_x2 <= r_x1;
        end
        if (w_en[2]) begin
            r_x3 <= r_x2;
        end
    end

    // Classify: range check, rectangle or trapezoid part, offset in the part.
    logic [WW-1:0] w_xw;
    logic          w_below;
    t_flags        w_p4_flags;

    always_comb begin
        w_xw           = WW'(r_x3);
        w_below        = (w_xw < r_d3_split);
        w_p4_flags.ok  = (w_xw < r_d3_size);
        w_p4_flags.div = r_d1_up ? w_below : !w_below;
    end

    t_flags        r_p4_flags;
    logic [WW-1:0] r_p4_y;
    logic [DW-1:0] r_p4_rbase;
    logic [DW-1:0] r_p4_cbase;

    always_ff @(posedge i_clk) begin
        if (w_en[P4]) begin
            r_p4_flags <= w_p4_flags;
            r_p4_y     <= w_below ? w_xw : (w_xw - r_d3_split);
            r_p4_rbase <= w_p4_flags.div ? r_d1_rbase : r_d1_tbase;
            r_p4_cbase <= w_p4_flags.div ? '0 : r_d1_cbase;
        end
    end

    // Bit steps, most significant row bit first.
    t_flags        w_flags [0:DW];
    logic [WW-1:0] w_y     [0:DW];
    logic [DW-1:0] w_acc   [0:DW];
    logic [WW-1:0] w_best  [0:DW];
    logic [DW-1:0] w_rbase [0:DW];
    logic [DW-1:0] w_cbase [0:DW];

    assign w_flags[0] = r_p4_flags;
    assign w_y[0]     = r_p4_y;
    assign w_acc[0]   = '0;
    assign w_best[0]  = '0;
    assign w_rbase[0] = r_p4_rbase;
    assign w_cbase[0] = r_p4_cbase;

    for (genvar s = 0; s < DW; s++) begin : g_step
        tric_step #(
            .DIM_WIDTH (DW),
            .WW        (WW),
            .BIT       (DW - 1 - s)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ld    (w_en[P4 + 1 + s]),
            .i_cols  (r_num_cols),
            .i_m     (r_d1_m),
            .i_h     (r_d1_h),
            .i_up    (r_d1_up),
            .i_flags (w_flags[s]),
            .i_y     (w_y[s]),
            .i_acc   (w_acc[s]),
            .i_best  (w_best[s]),
            .i_rbase (w_rbase[s]),
            .i_cbase (w_cbase[s]),
            .o_flags (w_flags[s+1]),
            .o_y     (w_y[s+1]),
            .o_acc   (w_acc[s+1]),
            .o_best  (w_best[s+1]),
            .o_rbase (w_rbase[s+1]),
            .o_cbase (w_cbase[s+1])
        );
    end

    // Output register: row and column, zero outside the triangle.
    // Upper trapezoid rows start one column further right per row.
    logic [WW-1:0] w_col_t;
    logic [DW-1:0] w_row;
    logic [DW-1:0] w_col;
    logic [DW-1:0] r_out_row;
    logic [DW-1:0] r_out_col;
    logic          r_out_ok;

    always_comb begin
        w_col_t = w_y[DW] - w_best[DW] + (r_d1_up ? WW'(w_acc[DW]) : WW'(0))
                + WW'(w_cbase[DW]);
        w_row   = w_rbase[DW] + w_acc[DW];
        w_col   = w_flags[DW].div ? w_y[DW][DW-1:0] : w_col_t[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_out_ok  <= w_flags[DW].ok;
            r_out_row <= w_flags[DW].ok ? w_row : '0;
            r_out_col <= w_flags[DW].ok ? w_col : '0;
        end
    end

    assign o_m_axis_tvalid   = r_v[NS-1];
    assign o_m_axis_tdata    = ODW'({r_out_col, r_out_row});
    assign o_m_axis_tuser[0] = r_out_ok;

    // An index outside the triangle reports the origin.
    `TRIC_ASSERT(a_zero_outside, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == '0, "out-of-range result has nonzero coordinates")
    // Input is refused only when every stage holds a transaction.
    `TRIC_ASSERT_ALWAYS(a_refuse_full, i_clk, !o_s_axis_tready |-> (&r_v), "input refused with an empty stage")

endmodule

`default_nettype wire

/* sv/tric_step.sv */
`default_nettype none

`include "assert_macros.svh"

// One bit step of the shared divide / triangular-root pipeline.
// Rectangle items do one restoring division step; trapezoid items test one
// bit of the row number against the cumulative element count.
module tric_step #(
    parameter int DIM_WIDTH = 16,
    parameter int WW        = 34,
    parameter int BIT       = 0
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_ld,
    input  wire logic [DIM_WIDTH-1:0]   i_cols,
    input  wire logic [DIM_WIDTH-1:0]   i_m,
    input  wire logic [DIM_WIDTH-1:0]   i_h,
    input  wire logic                   i_up,
    input  wire tric_pkg::t_flags       i_flags,
    input  wire logic [WW-1:0]          i_y,
    input  wire logic [DIM_WIDTH-1:0]   i_acc,
    input  wire logic [WW-1:0]          i_best,
    input  wire logic [DIM_WIDTH-1:0]   i_rbase,
    input  wire logic [DIM_WIDTH-1:0]   i_cbase,
    output tric_pkg::t_flags            o_flags,
    output logic [WW-1:0]               o_y,
    output logic [DIM_WIDTH-1:0]        o_acc,
    output logic [WW-1:0]               o_best,
    output logic [DIM_WIDTH-1:0]        o_rbase,
    output logic [DIM_WIDTH-1:0]        o_cbase
);
    import tric_pkg::*;

    localparam int FW = DIM_WIDTH + 2;
    localparam int PW = 2 * DIM_WIDTH + 2;

    logic [WW-1:0]        w_dsub;
    logic                 w_ge;
    logic [DIM_WIDTH-1:0] w_t;
    logic [FW-1:0]        w_fac;
    logic [PW-1:0]        w_prod;
    logic [WW-1:0]        w_cum;
    logic                 w_take;

    t_flags               r_flags;
    logic [WW-1:0]        r_y;
    logic [DIM_WIDTH-1:0] r_acc;
    logic [WW-1:0]        r_best;
    logic [DIM_WIDTH-1:0] r_rbase;
    logic [DIM_WIDTH-1:0] r_cbase;

    logic [WW-1:0]        n_y;
    logic [DIM_WIDTH-1:0] n_acc;
    logic [WW-1:0]        n_best;

    // Candidate with this step's bit set.
    assign w_t = i_acc | (DIM_WIDTH'(1) << BIT);

    // Division: compare the remainder with the shifted divisor.
    assign w_dsub = WW'(i_cols) << BIT;
    assign w_ge   = (i_y >= w_dsub);

    // Trapezoid: elements in the first w_t rows, first row holding i_m.
    always_comb begin
        if (i_up) begin
            w_fac = (FW'(i_m) << 1) + FW'(1) - FW'(w_t);
        end else begin
            w_fac = (FW'(i_m) << 1) - FW'(1) + FW'(w_t);
        end
        w_prod = PW'(w_t) * PW'(w_fac);
        w_cum  = WW'(w_prod >> 1);
        w_take = (w_t < i_h) && (w_cum <= i_y);
    end

    // Next values for either kind of item.
    always_comb begin
        n_y    = i_y;
        n_acc  = i_acc;
        n_best = i_best;
        if (i_flags.div) begin
            if (w_ge) begin
                n_y   = i_y - w_dsub;
                n_acc = w_t;
            end
        end else if (w_take) begin
            n_acc  = w_t;
            n_best = w_cum;
        end
    end

    // Stage register, loaded when the pipeline moves here.
    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_flags <= i_flags;
            r_y     <= n_y;
            r_acc   <= n_acc;
            r_best  <= n_best;
            r_rbase <= i_rbase;
            r_cbase <= i_cbase;
        end
    end

    assign o_flags = r_flags;
    assign o_y     = r_y;
    assign o_acc   = r_acc;
    assign o_best  = r_best;
    assign o_rbase = r_rbase;
    assign o_cbase = r_cbase;

    // A division step never grows the remainder.
    `TRIC_ASSERT(a_rem_no_grow, i_clk, i_rst_n, i_ld && i_flags.div |=> r_y <= $past(i_y), "remainder grew in a division step")
    // Only this step's bit of the row or quotient may change.
    `TRIC_ASSERT(a_one_bit, i_clk, i_rst_n, i_ld |=> (r_acc & ~(DIM_WIDTH'(1) << BIT)) == $past(i_acc & ~(DIM_WIDTH'(1) << BIT)), "step changed a bit other than its own")

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none

module tb_top;
    import tric_pkg::*;

    localparam int DW = 16;
    localparam int ODW = 32;
    localparam int LATENCY = 21;
    localparam longint CYCLE_LIMIT = 2000000;

    // One expected coordinate result.
    typedef struct packed {
        logic [DW-1:0] row;
        logic [DW-1:0] col;
        logic          ok;
    } t_coord;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IDX_W-1:0]      i_s_axis_tdata = '0;    // [31:0] linear_index
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [ODW-1:0]        o_m_axis_tdata;         // [15:0] out_row, [31:16] out_col
    logic [0:0]            o_m_axis_tuser;         // [0] in_range
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [DW:0]           i_cfg_data = '0;

    triangle_index_to_coordinate #(.DIM_WIDTH(DW)) uut (.*);

    always #10 i_clk = ~i_clk;

    // Shadow copy of the geometry registers.
    longint unsigned geo_rows, geo_cols, geo_upper;
    longint          geo_diag;

    logic [IDX_W-1:0] index_q[$];
    t_coord           coord_q[$];
    int               errors = 0;
    longint           cycles = 0;
    bit               quiet = 1'b0;
    bit               hold_tx = 1'b1;
    bit               in_taken = 1'b0;

    function automatic longint unsigned tri_cum(longint unsigned i, longint unsigned m, bit up);
        if (up) return (i * (2 * m - i + 1)) >> 1;
        return (i * (2 * m + i - 1)) >> 1;
    endfunction

    // Largest row i in [0, h-1] whose cumulative count does not exceed x.
    function automatic longint unsigned tri_row(longint unsigned x, longint unsigned m,
                                                 longint unsigned h, bit up);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = h - 1;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 1) >> 1);
            if (tri_cum(mid, m, up) <= x) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    // Expected coordinate of a linear index under the current geometry.
    function automatic t_coord index_to_coord(logic [IDX_W-1:0] idx);
        longint r, c, k, rr, m, h, left, r0, rest;
        longint unsigned x, rect, total, y, i, trap, row, col;
        t_coord res;
        x = idx;
        r = geo_rows;
        c = geo_cols;
        k = geo_diag;
        row = 0;
        col = 0;
        res.ok = 1'b0;
        if (r > 0 && c > 0) begin
            if (geo_upper != 0) begin
                rr = (k < 0) ? ((-k < r) ? -k : r) : 0;
                m = (k > 0) ? ((c - k > 0) ? c - k : 0) : c;
                left = r - rr;
                h = (m < left) ? m : left;
                rect = rr * c;
                total = rect + tri_cum(h, m, 1'b1);
                if (x < total) begin
                    res.ok = 1'b1;
                    if (x < rect) begin
                        row = x / c;
                        col = x % c;
                    end else begin
                        y = x - rect;
                        i = tri_row(y, m, h, 1'b1);
                        row = rr + i;
                        col = y - tri_cum(i, m, 1'b1) + i + ((k > 0) ? k : 0);
                    end
                end
            end else begin
                r0 = (k < 0) ? -k : 0;
                if (r0 < r) begin
                    m = (k > 0) ? ((k + 1 < c) ? k + 1 : c) : 1;
                    h = c - m + 1;
                    if (h > r - r0) h = r - r0;
                    rest = r - r0 - h;
                    trap = tri_cum(h, m, 1'b0);
                    if (x < trap + rest * c) begin
                        res.ok = 1'b1;
                        if (x < trap) begin
                            i = tri_row(x, m, h, 1'b0);
                            row = r0 + i;
                            col = x - tri_cum(i, m, 1'b0);
                        end else begin
                            y = x - trap;
                            row = r0 + h + y / c;
                            col = y % c;
                        end
                    end
                end
            end
        end
        res.row = row[DW-1:0];
        res.col = col[DW-1:0];
        return res;
    endfunction

    // Driver: presents queued indexes; a pending transaction is held until taken.
    always @(negedge i_clk) begin
        if (i_s_axis_tvalid && !in_taken) begin
            i_s_axis_tvalid <= 1'b1;
        end else if (i_rst_n && !hold_tx && index_q.size() > 0 &&
            (quiet || $urandom_range(99) >= 27)) begin
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= index_q[0];
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
        i_m_axis_tready <= quiet || ($urandom_range(99) >= 27);
    end

    // Monitor: predicts each accepted input and checks each result transaction.
    always @(posedge i_clk) begin
        t_coord got, want;
        cycles <= cycles + 1;
        in_taken = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (in_taken) begin
            coord_q.push_back(index_to_coord(i_s_axis_tdata));
            void'(index_q.pop_front());
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.row = o_m_axis_tdata[DW-1:0];
            got.col = o_m_axis_tdata[2*DW-1:DW];
            got.ok  = o_m_axis_tuser[0];
            if (coord_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors <= errors + 1;
            end else begin
                want = coord_q.pop_front();
                if (got.ok !== want.ok || got.row !== want.row || got.col !== want.col) begin
                    $display({"%0t: mismatch, expected row %0d col %0d ok %0d, ",
                              "actual row %0d col %0d ok %0d"},
                             $time, want.row, want.col, want.ok, got.row, got.col, got.ok);
                    errors <= errors + 1;
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, longint value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[DW:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_NUM_ROWS:    geo_rows  = value & 16'hFFFF;
            CFG_NUM_COLS:    geo_cols  = value & 16'hFFFF;
            CFG_DIAG_OFFSET: geo_diag  = value;
            CFG_UPPER_MODE:  geo_upper = value & 1;
            default: ;
        endcase
    endtask

    task automatic set_geometry(longint rows, longint cols, longint diag, longint up);
        write_reg(CFG_NUM_ROWS, rows);
        write_reg(CFG_NUM_COLS, cols);
        write_reg(CFG_DIAG_OFFSET, diag);
        write_reg(CFG_UPPER_MODE, up);
        // Let the geometry settle through its register stages.
        repeat (4) @(negedge i_clk);
    endtask

    // Wait until the block has drained every queued index and result.
    task automatic drain();
        hold_tx = 1'b0;
        while (index_q.size() > 0 || coord_q.size() > 0) @(negedge i_clk);
        hold_tx = 1'b1;
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // Element count of the current triangle, used to aim random indexes.
    function automatic longint unsigned tri_size();
        longint unsigned lo, hi, mid;
        t_coord t;
        lo = 0;
        hi = 64'h1_0000_0000;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            t = index_to_coord(mid[31:0]);
            if (t.ok) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    task automatic random_phase(int count);
        longint unsigned n;
        logic [31:0] idx;
        n = tri_size();
        for (int j = 0; j < count; j++) begin
            if (n > 0 && $urandom_range(9) < 8) begin
                idx = (n > 3 && $urandom_range(3) == 0)
                    ? 32'($urandom_range(1) ? n - 1 - $urandom_range(2) : $urandom_range(2))
                    : 32'({$urandom, $urandom} % n);
            end else if ($urandom_range(1)) begin
                idx = 32'(n + $urandom_range(3));
            end else begin
                idx = $urandom;
            end
            index_q.push_back(idx);
        end
        drain();
    endtask

    int rows, cols, diag;

    initial begin
        geo_rows = 0;
        geo_cols = 0;
        geo_diag = 0;
        geo_upper = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty matrix after reset, extreme indexes.
        index_q.push_back(32'd0);
        index_q.push_back(32'hFFFF_FFFF);
        drain();
        set_geometry(5, 4, 0, 0);
        for (int j = 0; j < 8; j++) index_q.push_back(j);
        index_q.push_back(32'hFFFF_FFFF);
        drain();
        set_geometry(5, 4, -2, 1);
        for (int j = 0; j < 8; j++) index_q.push_back(j * 2);
        drain();
        set_geometry(65535, 65535, 65535, 1);
        index_q.push_back(0);
        index_q.push_back(1);
        drain();
        set_geometry(65535, 65535, -65535, 0);
        index_q.push_back(0);
        drain();
        set_geometry(65535, 65535, 0, 1);
        index_q.push_back(32'hFFFF_FFFF);
        index_q.push_back(32'h8000_0000);
        drain();

        // Random geometry phases; the middle ones run without idling.
        for (int p = 0; p < 36; p++) begin
            quiet = (p >= 12 && p < 16);
            case ($urandom_range(3))
                0: begin
                    rows = $urandom_range(65535);
                    cols = $urandom_range(65535);
                end
                1: begin
                    rows = $urandom_range(1, 20);
                    cols = $urandom_range(1, 20);
                end
                2: begin
                    rows = $urandom_range(1, 400);
                    cols = $urandom_range(1, 400);
                end
                default: begin
                    rows = $urandom_range(1) ? 65535 : $urandom_range(3);
                    cols = $urandom_range(1) ? 65535 : $urandom_range(3);
                end
            endcase
            diag = (p % 5 == 4) ? ($urandom_range(1) ? 65535 : -65535)
                 : int'($urandom_range(2 * (cols + 2))) - (rows + 2);
            if (diag > 65535) diag = 65535;
            if (diag < -65535) diag = -65535;
            set_geometry(rows, cols, diag, $urandom_range(1));
            random_phase(50);
        end
        quiet = 1'b0;

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+sv
sv/tric_pkg.sv
sv/tric_step.sv
sv/triangle_index_to_coordinate.sv
tb/sv/tb_top.sv
